[src/fan_curve_controller_assert.svh]
// ----------------------------------------------------------------------------
// Fan curve controller assertion macros
// Shorthand for concurrent checks clocked on clk and muted during reset.
// ----------------------------------------------------------------------------
`ifndef FAN_CURVE_CONTROLLER_ASSERT_SVH
`define FAN_CURVE_CONTROLLER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FCC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fan_curve_controller: check failed");

// Consequent must hold in the cycle after the antecedent.
`define FCC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fan_curve_controller: check failed");

`endif

[src/fcc_pkg.sv]
// ----------------------------------------------------------------------------
// Fan curve controller package
// Field widths, register indexes, reset values and control structures.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fcc_pkg;

	localparam int TEMP_W  = 12;
	localparam int HYST_W  = 10;
	localparam int DUTY_W  = 7;
	localparam int NOISE_W = 8;
	localparam int CHAN_W  = 8;
	localparam int IDX_W   = 3;
	localparam int DATA_W  = 12;
	localparam int SPAN_W  = 12;
	localparam int SQ_W    = 24;
	localparam int NUM_W   = 31;
	localparam int SHIFT_W = 3;

	localparam logic [DUTY_W-1:0] FULL_DUTY = 7'd100;
	localparam logic [SHIFT_W-1:0] DIV_TOP_SHIFT = 3'd6;

	// Configuration register indexes.
	localparam logic [IDX_W-1:0] REG_THRESHOLD = 3'd0;
	localparam logic [IDX_W-1:0] REG_HYSTERESIS = 3'd1;
	localparam logic [IDX_W-1:0] REG_HIGH = 3'd2;
	localparam logic [IDX_W-1:0] REG_MIN_DUTY = 3'd3;
	localparam logic [IDX_W-1:0] REG_NOISE = 3'd4;
	localparam logic [IDX_W-1:0] REG_FAN_PRESENT = 3'd5;
	localparam logic [IDX_W-1:0] REG_FAN_CHANNEL = 3'd6;

	// Reset values of the registers.
	localparam logic signed [TEMP_W-1:0] RST_THRESHOLD = 12'sd640;
	localparam logic [HYST_W-1:0] RST_HYSTERESIS = 10'd32;
	localparam logic signed [TEMP_W-1:0] RST_HIGH = 12'sd960;
	localparam logic [DUTY_W-1:0] RST_MIN_DUTY = 7'd30;
	localparam logic [NOISE_W-1:0] RST_NOISE = 8'd8;
	localparam logic [CHAN_W-1:0] RST_FAN_CHANNEL = 8'd0;

	typedef struct packed {
		logic                load;      // capture the accepted sample
		logic                take;      // sample passed the deadband
		logic                set_band;  // load the duty from the band logic
		logic                mul_sq;    // square offset and span
		logic                mul_k;     // scale offset square by the ramp height
		logic                div_step;  // one restoring divide step
		logic                div_last;  // final divide step, form the duty
		logic [SHIFT_W-1:0]  div_shift;
		logic                commit;    // store duty and present the result
	} fcc_cmd_t;

	typedef struct packed {
		logic noise;      // change within deadband
		logic fan;        // fan fitted
		logic ramp;       // sample lies on the quadratic ramp
		logic same;       // new duty equals the current duty
		logic slot_free;  // output register can take a beat
	} fcc_status_t;

endpackage

[src/fcc_stream_if.sv]
// ----------------------------------------------------------------------------
// Fan curve controller stream interfaces
// Valid/ready channels for temperature samples and PWM duty writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface fcc_sample_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [fcc_pkg::TEMP_W-1:0]    sample_temp;

	modport source (output valid, output sample_temp, input ready);
	modport sink (input valid, input sample_temp, output ready);
endinterface

interface fcc_duty_if;
	logic                           valid;
	logic                           ready;
	logic [fcc_pkg::DUTY_W-1:0]     duty_percent;
	logic [fcc_pkg::CHAN_W-1:0]     pwm_register;

	modport source (output valid, output duty_percent, output pwm_register, input ready);
	modport sink (input valid, input duty_percent, input pwm_register, output ready);
endinterface

[src/fcc_datapath.sv]
// ----------------------------------------------------------------------------
// Fan curve controller datapath
// Configuration registers, deadband and band tests, ramp multipliers,
// restoring divider and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcc_datapath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [fcc_pkg::IDX_W-1:0]              cfg_index,
	input  logic [fcc_pkg::DATA_W-1:0]             cfg_wdata,
	input  logic signed [fcc_pkg::TEMP_W-1:0]      sample_temp,
	input  fcc_pkg::fcc_cmd_t                      cmd,
	output fcc_pkg::fcc_status_t                   status,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [fcc_pkg::DUTY_W-1:0]             duty_percent,
	output logic [fcc_pkg::CHAN_W-1:0]             pwm_register
);

	logic signed [fcc_pkg::TEMP_W-1:0]  threshold_q;
	logic [fcc_pkg::HYST_W-1:0]         hysteresis_q;
	logic signed [fcc_pkg::TEMP_W-1:0]  high_q;
	logic [fcc_pkg::DUTY_W-1:0]         min_duty_q;
	logic [fcc_pkg::NOISE_W-1:0]        noise_q;
	logic                               fan_present_q;
	logic [fcc_pkg::CHAN_W-1:0]         channel_q;

	logic signed [fcc_pkg::TEMP_W-1:0]  sample_q;
	logic signed [fcc_pkg::TEMP_W-1:0]  accepted_q;
	logic [fcc_pkg::DUTY_W-1:0]         current_q;
	logic [fcc_pkg::DUTY_W-1:0]         duty_q;
	logic [fcc_pkg::SQ_W-1:0]           dsq_q;
	logic [fcc_pkg::SQ_W-1:0]           den_q;
	logic [fcc_pkg::NUM_W-1:0]          rem_q;
	logic [fcc_pkg::DUTY_W-2:0]         quot_q;
	logic                               out_valid_q;
	logic [fcc_pkg::DUTY_W-1:0]         out_duty_q;
	logic [fcc_pkg::CHAN_W-1:0]         out_chan_q;

	logic signed [fcc_pkg::TEMP_W:0]    diff;
	logic [fcc_pkg::TEMP_W:0]           diff_abs;
	logic signed [fcc_pkg::TEMP_W+1:0]  band_lo;
	logic signed [fcc_pkg::TEMP_W+1:0]  band_hi;
	logic signed [fcc_pkg::TEMP_W+1:0]  t_ext;
	logic                               below_band;
	logic [fcc_pkg::DUTY_W-1:0]         min_eff;
	logic [fcc_pkg::DUTY_W-1:0]         ramp_k;
	logic [fcc_pkg::DUTY_W-1:0]         band_duty;
	logic signed [fcc_pkg::TEMP_W:0]    offset;
	logic signed [fcc_pkg::TEMP_W:0]    span;
	logic [fcc_pkg::SPAN_W-1:0]         offset_u;
	logic [fcc_pkg::SPAN_W-1:0]         span_u;
	logic [fcc_pkg::NUM_W-1:0]          den_shifted;
	logic [fcc_pkg::NUM_W:0]            trial;
	logic                               qbit;
	logic [fcc_pkg::DUTY_W-1:0]         quot_next;

	// Deadband test against the last accepted temperature.
	assign diff = {sample_q[fcc_pkg::TEMP_W-1], sample_q}
		- {accepted_q[fcc_pkg::TEMP_W-1], accepted_q};
	assign diff_abs = diff[fcc_pkg::TEMP_W] ? (fcc_pkg::TEMP_W+1)'(-diff)
		: (fcc_pkg::TEMP_W+1)'(diff);

	// Band edges need two extra bits for the sum and difference.
	assign t_ext = (fcc_pkg::TEMP_W+2)'(sample_q);
	assign band_lo = (fcc_pkg::TEMP_W+2)'(threshold_q)
		- $signed({4'b0, hysteresis_q});
	assign band_hi = (fcc_pkg::TEMP_W+2)'(threshold_q)
		+ $signed({4'b0, hysteresis_q});
	assign below_band = t_ext < band_lo;

	assign min_eff = (min_duty_q > fcc_pkg::FULL_DUTY) ? fcc_pkg::FULL_DUTY : min_duty_q;
	assign ramp_k = fcc_pkg::FULL_DUTY - min_eff;

	always_comb begin
		if (below_band) begin
			band_duty = '0;
		end else if (t_ext <= band_hi) begin
			band_duty = (current_q != '0) ? min_eff : '0;
		end else begin
			band_duty = fcc_pkg::FULL_DUTY;
		end
	end

	// On the ramp both offset and span are positive and below 4096.
	assign offset = {sample_q[fcc_pkg::TEMP_W-1], sample_q}
		- {threshold_q[fcc_pkg::TEMP_W-1], threshold_q};
	assign span = {high_q[fcc_pkg::TEMP_W-1], high_q}
		- {threshold_q[fcc_pkg::TEMP_W-1], threshold_q};
	assign offset_u = offset[fcc_pkg::SPAN_W-1:0];
	assign span_u = span[fcc_pkg::SPAN_W-1:0];

	assign den_shifted = fcc_pkg::NUM_W'({7'b0, den_q} << cmd.div_shift);
	assign trial = {1'b0, rem_q} - {1'b0, den_shifted};
	assign qbit = ~trial[fcc_pkg::NUM_W];
	assign quot_next = {quot_q, qbit};

	assign status.noise = diff_abs <= {5'b0, noise_q};
	assign status.fan = fan_present_q;
	assign status.ramp = (t_ext > band_hi) && (sample_q < high_q);
	assign status.same = duty_q == current_q;
	assign status.slot_free = ~out_valid_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= fcc_pkg::RST_THRESHOLD;
			hysteresis_q <= fcc_pkg::RST_HYSTERESIS;
			high_q <= fcc_pkg::RST_HIGH;
			min_duty_q <= fcc_pkg::RST_MIN_DUTY;
			noise_q <= fcc_pkg::RST_NOISE;
			fan_present_q <= 1'b0;
			channel_q <= fcc_pkg::RST_FAN_CHANNEL;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fcc_pkg::REG_THRESHOLD: threshold_q <= $signed(cfg_wdata[fcc_pkg::TEMP_W-1:0]);
				fcc_pkg::REG_HYSTERESIS: hysteresis_q <= cfg_wdata[fcc_pkg::HYST_W-1:0];
				fcc_pkg::REG_HIGH: high_q <= $signed(cfg_wdata[fcc_pkg::TEMP_W-1:0]);
				fcc_pkg::REG_MIN_DUTY: min_duty_q <= cfg_wdata[fcc_pkg::DUTY_W-1:0];
				fcc_pkg::REG_NOISE: noise_q <= cfg_wdata[fcc_pkg::NOISE_W-1:0];
				fcc_pkg::REG_FAN_PRESENT: fan_present_q <= cfg_wdata[0];
				fcc_pkg::REG_FAN_CHANNEL: channel_q <= cfg_wdata[fcc_pkg::CHAN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accepted_q <= '0;
			current_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.take) begin
				accepted_q <= sample_q;
			end
			if (cmd.commit) begin
				current_q <= duty_q;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= sample_temp;
		end
		if (cmd.set_band) begin
			duty_q <= band_duty;
		end
		if (cmd.mul_sq) begin
			dsq_q <= {{(fcc_pkg::SQ_W-fcc_pkg::SPAN_W){1'b0}}, offset_u}
				* {{(fcc_pkg::SQ_W-fcc_pkg::SPAN_W){1'b0}}, offset_u};
			den_q <= {{(fcc_pkg::SQ_W-fcc_pkg::SPAN_W){1'b0}}, span_u}
				* {{(fcc_pkg::SQ_W-fcc_pkg::SPAN_W){1'b0}}, span_u};
		end
		if (cmd.mul_k) begin
			rem_q <= {{(fcc_pkg::NUM_W-fcc_pkg::DUTY_W){1'b0}}, ramp_k}
				* {{(fcc_pkg::NUM_W-fcc_pkg::SQ_W){1'b0}}, dsq_q};
			quot_q <= '0;
		end
		if (cmd.div_step) begin
			if (qbit) begin
				rem_q <= trial[fcc_pkg::NUM_W-1:0];
			end
			quot_q <= quot_next[fcc_pkg::DUTY_W-2:0];
			if (cmd.div_last) begin
				duty_q <= min_eff + quot_next;
			end
		end
		if (cmd.commit) begin
			out_duty_q <= duty_q;
			out_chan_q <= channel_q;
		end
	end

	assign out_valid = out_valid_q;
	assign duty_percent = out_duty_q;
	assign pwm_register = out_chan_q;

endmodule

[src/fcc_controller.sv]
// ----------------------------------------------------------------------------
// Fan curve controller sequencer
// Steps one sample through deadband, band decision, ramp and result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fcc_controller (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  fcc_pkg::fcc_status_t    status,
	output fcc_pkg::fcc_cmd_t       cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_MUL_SQ,
		S_MUL_K,
		S_DIV,
		S_FINISH
	} state_t;

	state_t                           state_q;
	logic [fcc_pkg::SHIFT_W-1:0]      shift_q;

	assign in_ready = state_q == S_IDLE;

	always_comb begin
		cmd = '0;
		cmd.div_shift = shift_q;
		unique case (state_q)
			S_IDLE: cmd.load = in_valid;
			S_EVAL: begin
				cmd.take = ~status.noise;
				cmd.set_band = ~status.noise & status.fan & ~status.ramp;
			end
			S_MUL_SQ: cmd.mul_sq = 1'b1;
			S_MUL_K: cmd.mul_k = 1'b1;
			S_DIV: begin
				cmd.div_step = 1'b1;
				cmd.div_last = shift_q == '0;
			end
			S_FINISH: cmd.commit = ~status.same & status.slot_free;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			shift_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					if (status.noise || !status.fan) begin
						state_q <= S_IDLE;
					end else if (status.ramp) begin
						state_q <= S_MUL_SQ;
					end else begin
						state_q <= S_FINISH;
					end
				end
				S_MUL_SQ: state_q <= S_MUL_K;
				S_MUL_K: begin
					shift_q <= fcc_pkg::DIV_TOP_SHIFT;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (shift_q == '0) begin
						state_q <= S_FINISH;
					end else begin
						shift_q <= shift_q - fcc_pkg::SHIFT_W'(1);
					end
				end
				S_FINISH: begin
					// An unchanged duty ends quietly; a new one waits for the output slot.
					if (status.same || status.slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[src/fan_curve_controller.sv]
// ----------------------------------------------------------------------------
// Fan curve controller
// Turns temperature samples into PWM duty writes along a quadratic fan curve.
// ----------------------------------------------------------------------------
// Samples beat in on the samples channel; duty writes beat out on the writes
// channel, at most one per sample. A sample whose change from the last
// accepted temperature is within the noise band yields nothing, as does any
// sample while no fan is fitted, and any sample whose duty equals the current
// one. The user must write the registers through cfg_we, cfg_index and
// cfg_wdata only while the block is idle; the block does not enforce this.
// Timing: one sample is in flight at a time. A deadband sample returns to
// idle after the evaluate state; a band decision goes on to the finish
// state; a ramp sample passes S_MUL_SQ, S_MUL_K and a seven-step restoring
// divider. The next sample is taken the cycle after the result is stored.
// The result sits in an output register, so the sequencer only waits when a
// new result meets an earlier beat that the receiver has not yet taken.
// Reset loads the register defaults, clears the accepted temperature and
// the current duty (fan off) and empties the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "fan_curve_controller_assert.svh"

module fan_curve_controller (
	input  logic                          clk,
	input  logic                          arst_n,
	fcc_sample_if.sink                    samples,
	fcc_duty_if.source                    writes,
	input  logic                          cfg_we,
	input  logic [fcc_pkg::IDX_W-1:0]     cfg_index,
	input  logic [fcc_pkg::DATA_W-1:0]    cfg_wdata
);

	fcc_pkg::fcc_cmd_t      cmd;
	fcc_pkg::fcc_status_t   status;

	fcc_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (samples.ready),
		.status   (status),
		.cmd      (cmd)
	);

	fcc_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.sample_temp  (samples.sample_temp),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (writes.valid),
		.out_ready    (writes.ready),
		.duty_percent (writes.duty_percent),
		.pwm_register (writes.pwm_register)
	);

	`FCC_ASSERT_NOW(a_duty_range, writes.valid, writes.duty_percent <= fcc_pkg::FULL_DUTY)
	`FCC_ASSERT_NEXT(a_busy_after_accept, samples.valid && samples.ready, !samples.ready)
	`FCC_ASSERT_NEXT(a_commit_shows_beat, cmd.commit, writes.valid)
	`FCC_ASSERT_NOW(a_commit_slot_free, cmd.commit, !writes.valid || writes.ready)

endmodule

[tb/sv/tb_fan_curve_controller.sv]
// ----------------------------------------------------------------------------
// Fan curve controller testbench
// Sends temperature samples with random pacing, predicts the PWM duty write
// for each one from a behavioral copy of the fan curve, and checks every
// duty beat against it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fan_curve_controller;
	import fcc_pkg::*;

	localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int SETTLE_CYCLES = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TARGET_ITEMS = 1150;
	localparam int PHASE_ITEMS = 100;
	localparam int MAX_GAP = 11;
	localparam int DIR_ROWS = 36;

	typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

	typedef struct {
		row_kind_t        kind;
		logic [IDX_W-1:0] idx;
		int               value;
		bit               typed;
		bit               exp_has;
		int               exp_duty;
	} dir_row_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		logic [CHAN_W-1:0] chan;
	} duty_beat_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0] cfg_wdata;

	fcc_sample_if sample_ch();
	fcc_duty_if write_ch();

	fan_curve_controller DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (sample_ch),
		.writes    (write_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Register copies and curve state kept by the predictor.
	int thr_temp, hyst_temp, high_temp, min_duty_cfg, noise_cfg, fan_on, chan_cfg;
	int seen_temp, fan_duty;

	duty_beat_t pending_writes[$];
	int error_count = 0;
	int beat_count = 0;
	int sample_count = 0;
	int passed_count = 0;
	int write_count = 0;
	int phase_count = 0;
	bit no_idle = 1'b0;

	dir_row_t dir_rows [DIR_ROWS];

	function automatic void reset_model();
		thr_temp = RST_THRESHOLD;
		hyst_temp = RST_HYSTERESIS;
		high_temp = RST_HIGH;
		min_duty_cfg = RST_MIN_DUTY;
		noise_cfg = RST_NOISE;
		fan_on = 0;
		chan_cfg = RST_FAN_CHANNEL;
		seen_temp = 0;
		fan_duty = 0;
	endfunction

	function automatic void apply_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
		case (idx)
			REG_THRESHOLD: thr_temp = $signed(data[TEMP_W-1:0]);
			REG_HYSTERESIS: hyst_temp = data[HYST_W-1:0];
			REG_HIGH: high_temp = $signed(data[TEMP_W-1:0]);
			REG_MIN_DUTY: min_duty_cfg = data[DUTY_W-1:0];
			REG_NOISE: noise_cfg = data[NOISE_W-1:0];
			REG_FAN_PRESENT: fan_on = data[0];
			REG_FAN_CHANNEL: chan_cfg = data[CHAN_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic int curve_duty(int t);
		int full;
		int mn;
		longint d, span, den, num, q;
		full = FULL_DUTY;
		mn = (min_duty_cfg > full) ? full : min_duty_cfg;
		if (t < thr_temp - hyst_temp)
			return 0;
		if (t <= thr_temp + hyst_temp)
			return (fan_duty != 0) ? mn : 0;
		if (t < high_temp) begin
			// On the ramp both t and high_temp lie above the threshold.
			d = t - thr_temp;
			span = high_temp - thr_temp;
			den = span * span;
			num = mn * den + (full - mn) * d * d;
			q = num / den;
			if (q > full)
				q = full;
			if (q < 0)
				q = 0;
			return int'(q);
		end
		return full;
	endfunction

	function automatic bit predict_write(input int t, output bit passed, output duty_beat_t beat);
		int diff;
		int duty;
		passed = 1'b0;
		beat = '0;
		diff = t - seen_temp;
		if (diff < 0)
			diff = -diff;
		if (diff <= noise_cfg)
			return 1'b0;
		passed = 1'b1;
		seen_temp = t;
		if (fan_on == 0)
			return 1'b0;
		duty = curve_duty(t);
		if (duty == fan_duty)
			return 1'b0;
		fan_duty = duty;
		beat.duty = duty[DUTY_W-1:0];
		beat.chan = chan_cfg[CHAN_W-1:0];
		return 1'b1;
	endfunction

	task automatic send_sample(input logic [TEMP_W-1:0] raw, output bit has,
			output duty_beat_t beat);
		int gap;
		bit passed;
		gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.sample_temp <= raw;
		do @(posedge clk); while (!sample_ch.ready);
		has = predict_write($signed(raw), passed, beat);
		sample_count++;
		if (passed)
			passed_count++;
		if (has)
			pending_writes.push_back(beat);
	endtask

	// An ignored sample leaves nothing pending, so the block may still be busy
	// with it; the extra cycles cover the longest ramp calculation.
	task automatic settle();
		sample_ch.valid <= 1'b0;
		while (pending_writes.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		apply_reg(idx, data);
		write_count++;
	endtask

	// Receiver: stalls a random number of cycles before each beat.
	initial begin : duty_sink
		int stall;
		write_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
			if (stall > 0) begin
				write_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			write_ch.ready <= 1'b1;
			do @(posedge clk); while (!(write_ch.valid && write_ch.ready));
		end
	end

	always @(posedge clk) begin
		duty_beat_t exp_beat;
		if (arst_n && write_ch.valid && write_ch.ready) begin
			beat_count++;
			if (pending_writes.size() == 0) begin
				$error("unexpected duty write: duty_percent %0d pwm_register %0d",
					write_ch.duty_percent, write_ch.pwm_register);
				error_count++;
			end else begin
				exp_beat = pending_writes.pop_front();
				if (write_ch.duty_percent !== exp_beat.duty) begin
					$error("duty_percent: expected %0d, got %0d",
						exp_beat.duty, write_ch.duty_percent);
					error_count++;
				end
				if (write_ch.pwm_register !== exp_beat.chan) begin
					$error("pwm_register: expected %0d, got %0d",
						exp_beat.chan, write_ch.pwm_register);
					error_count++;
				end
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((sample_ch.valid && sample_ch.ready) || (write_ch.valid && write_ch.ready) ||
					cfg_we || !arst_n)
				quiet = 0;
			else
				quiet++;
		end
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		bit has;
		duty_beat_t beat;
		int base, phase_base, pick, t, band_lo, band_hi;
		int r_thr, r_high, r_hyst, r_min, r_noise, r_fan, r_chan;
		logic [TEMP_W-1:0] raw;
		logic [DATA_W-1:0] wdata;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_THRESHOLD;
		cfg_wdata <= '0;
		sample_ch.valid <= 1'b0;
		sample_ch.sample_temp <= '0;
		reset_model();

		// Directed rows start from the reset defaults with no fan fitted.
		dir_rows = '{
			'{ROW_SAMPLE, REG_THRESHOLD,   100,   1'b1, 1'b0, 0},
			'{ROW_WRITE,  REG_FAN_PRESENT, 1,     1'b0, 1'b0, 0},
			'{ROW_WRITE,  REG_FAN_CHANNEL, 255,   1'b0, 1'b0, 0},
			'{ROW_SAMPLE, REG_THRESHOLD,   2047,  1'b1, 1'b1, 100},
			'{ROW_SAMPLE, REG_THRESHOLD,   2040,  1'b1, 1'b0, 0},
			'{ROW_SAMPLE, REG_THRESHOLD,   -2048, 1'b1, 1'b1, 0},
			'{ROW_SAMPLE, REG_THRESHOLD,   640,   1'b1, 1'b0, 0},
			'{ROW_SAMPLE, REG_THRESHOLD,   700,   1'b0, 1'b0, 0},
			'{ROW_SAMPLE, REG_THRESHOLD,   660,   1'b0, 1'b0, 0},
			'{ROW_SAMPLE, REG_THRESHOLD,   500,   1'b1, 1'b1, 0},
			'{ROW_WRITE,  REG_MIN_DUTY,    127,   1'b0, 1'b0, 0},
			'{ROW_SAMPLE, REG_THRESHOLD,   700,   1'b1, 1'b1, 100},
			'{ROW_WRITE,  REG_MIN_DUTY,    0,     1'b0, 1'b0, 0},
			'{ROW_SAMPLE, REG_THRESHOLD,   959,   1'b0, 1'b0, 0},
			'{ROW_SAMPLE, REG_THRESHOLD,   960,   1'b1, 1'b0, 0},
			'{ROW_WRITE,  REG_HIGH,        600,   1'b0, 1'b0, 0},
			'{ROW_SAMPLE, REG_THRESHOLD,   0,     1'b1, 1'b1, 0},
			'{ROW_SAMPLE, REG_THRESHOLD,   673,   1'b1, 1'b1, 100},
			'{ROW_WRITE,  REG_UNUSED,      4095,  1'b0, 1'b0, 0},
			'{ROW_SAMPLE, REG_THRESHOLD,   700,   1'b1, 1'b0, 0},
			'{ROW_WRITE,  REG_FAN_CHANNEL, 0,     1'b0, 1'b0, 0},
			'{ROW_WRITE,  REG_NOISE,       255,   1'b0, 1'b0, 0},
			'{ROW_WRITE,  REG_HYSTERESIS,  1023,  1'b0, 1'b0, 0},
			'{ROW_WRITE,  REG_THRESHOLD,   -2048, 1'b0, 1'b0, 0},
			'{ROW_WRITE,  REG_HIGH,        2047,  1'b0, 1'b0, 0},
			'{ROW_SAMPLE, REG_THRESHOLD,   -2048, 1'b0, 1'b0, 0},
			'{ROW_SAMPLE, REG_THRESHOLD,   -1000, 1'b0, 1'b0, 0},
			'{ROW_SAMPLE, REG_THRESHOLD,   -900,  1'b1, 1'b0, 0},
			'{ROW_WRITE,  REG_NOISE,       0,     1'b0, 1'b0, 0},
			'{ROW_WRITE,  REG_HYSTERESIS,  0,     1'b0, 1'b0, 0},
			'{ROW_WRITE,  REG_MIN_DUTY,    100,   1'b0, 1'b0, 0},
			'{ROW_SAMPLE, REG_THRESHOLD,   -899,  1'b0, 1'b0, 0},
			'{ROW_WRITE,  REG_FAN_PRESENT, 0,     1'b0, 1'b0, 0},
			'{ROW_SAMPLE, REG_THRESHOLD,   2047,  1'b1, 1'b0, 0},
			'{ROW_WRITE,  REG_FAN_PRESENT, 1,     1'b0, 1'b0, 0},
			'{ROW_SAMPLE, REG_THRESHOLD,   2046,  1'b1, 1'b0, 0}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			if (dir_rows[i].kind == ROW_WRITE) begin
				settle();
				write_reg(dir_rows[i].idx, dir_rows[i].value[DATA_W-1:0]);
			end else begin
				send_sample(dir_rows[i].value[TEMP_W-1:0], has, beat);
				if (dir_rows[i].typed && (has != dir_rows[i].exp_has ||
						(has && beat.duty != dir_rows[i].exp_duty))) begin
					$error("directed row %0d duty_percent: expected %0s%0d, predicted %0s%0d",
						i, dir_rows[i].exp_has ? "" : "none ", dir_rows[i].exp_duty,
						has ? "" : "none ", beat.duty);
					error_count++;
				end
			end
		end

		base = sample_count;
		while (sample_count - base < TARGET_ITEMS) begin
			settle();
			// Every third phase runs with both sides at full rate.
			no_idle = (phase_count % 3 == 2);

			pick = $urandom_range(0, 9);
			if (pick < 2)
				r_thr = $urandom_range(0, 1) ? 2047 : -2048;
			else
				r_thr = int'($urandom_range(0, 1600)) - 800;
			pick = $urandom_range(0, 9);
			if (pick < 2)
				r_high = int'($urandom_range(0, 4095)) - 2048;
			else if (pick < 3)
				r_high = $urandom_range(0, 1) ? 2047 : -2048;
			else begin
				r_high = r_thr + int'($urandom_range(1, 700));
				if (r_high > 2047)
					r_high = 2047;
			end
			r_hyst = ($urandom_range(0, 9) == 0) ? 1023 : $urandom_range(0, 48);
			r_min = $urandom_range(0, 127);
			r_noise = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 12);
			r_fan = ($urandom_range(0, 9) != 0);
			r_chan = $urandom_range(0, 255);

			// Bits above each register's width carry noise.
			write_reg(REG_THRESHOLD, r_thr[DATA_W-1:0]);
			wdata = $urandom_range(0, 4095);
			wdata[HYST_W-1:0] = r_hyst[HYST_W-1:0];
			write_reg(REG_HYSTERESIS, wdata);
			write_reg(REG_HIGH, r_high[DATA_W-1:0]);
			wdata = $urandom_range(0, 4095);
			wdata[DUTY_W-1:0] = r_min[DUTY_W-1:0];
			write_reg(REG_MIN_DUTY, wdata);
			wdata = $urandom_range(0, 4095);
			wdata[NOISE_W-1:0] = r_noise[NOISE_W-1:0];
			write_reg(REG_NOISE, wdata);
			wdata = $urandom_range(0, 4095);
			wdata[0] = r_fan[0];
			write_reg(REG_FAN_PRESENT, wdata);
			wdata = $urandom_range(0, 4095);
			wdata[CHAN_W-1:0] = r_chan[CHAN_W-1:0];
			write_reg(REG_FAN_CHANNEL, wdata);

			band_lo = r_thr - r_hyst - 64;
			if (band_lo < -2048)
				band_lo = -2048;
			band_hi = ((r_high > r_thr + r_hyst) ? r_high : r_thr + r_hyst) + 64;
			if (band_hi > 2047)
				band_hi = 2047;

			phase_base = sample_count;
			while (sample_count - phase_base < PHASE_ITEMS &&
					sample_count - base < TARGET_ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 65) begin
					// Most samples land across the band and the ramp.
					t = band_lo + int'($urandom_range(0, band_hi - band_lo));
					raw = t[TEMP_W-1:0];
				end else if (pick < 85) begin
					raw = $urandom_range(0, 4095);
				end else begin
					// Small moves that straddle the noise deadband edge.
					t = seen_temp + int'($urandom_range(0, 2 * noise_cfg + 2)) - (noise_cfg + 1);
					if (t > 2047)
						t = 2047;
					if (t < -2048)
						t = -2048;
					raw = t[TEMP_W-1:0];
				end
				send_sample(raw, has, beat);
			end
			phase_count++;
		end

		settle();
		$display("Sent %0d samples, %0d past the noise deadband, over %0d random settings.",
			sample_count, passed_count, phase_count);
		$display("Checked %0d duty writes across %0d register writes.", beat_count, write_count);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
